/* hw/rtl/kcl_pkg.sv */
`default_nettype none
package kcl_pkg;

	localparam int unsigned BUTTONS_W       = 6;
	localparam int unsigned BUTTON_COUNT    = 6;
	localparam int unsigned SCAN_BUTTONS    = (BUTTON_COUNT < BUTTONS_W) ? BUTTON_COUNT : BUTTONS_W;
	localparam int unsigned DIGIT_W         = 3;
	localparam int unsigned CODE_REG_DIGITS = 4;
	localparam int unsigned CODE_W          = CODE_REG_DIGITS * DIGIT_W;
	localparam int unsigned SECONDS_W       = 16;
	localparam int unsigned FAIL_W          = 3;
	localparam int unsigned HELD_W          = 2;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned CFG_DATA_W      = 16;

	localparam logic [FAIL_W-1:0]    FAIL_MAX    = '1;
	localparam logic [SECONDS_W-1:0] SECONDS_MAX = '1;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_BUTTON = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_USER_CODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_CODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_SECONDS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_FAILURES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_FAILURES = 3'd4;

	localparam logic [CODE_W-1:0]    USER_CODE_RST     = 12'd585;
	localparam logic [CODE_W-1:0]    OVERRIDE_CODE_RST = 12'd2925;
	localparam logic [SECONDS_W-1:0] LOCK_SECONDS_RST  = 16'd60;
	localparam logic [FAIL_W-1:0]    WARN_FAILURES_RST = 3'd3;
	localparam logic [FAIL_W-1:0]    LOCK_FAILURES_RST = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_GRANTED  = 3'd1,
		EV_DENIED   = 3'd2,
		EV_WARNING  = 3'd3,
		EV_LOCKDOWN = 3'd4,
		EV_ADMIN    = 3'd5,
		EV_IGNORED  = 3'd6,
		EV_EXPIRED  = 3'd7
	} event_t;

	typedef struct packed {
		logic                 opcode;
		logic [BUTTONS_W-1:0] buttons;
	} key_word_t;

	typedef struct packed {
		event_t            event_res;
		logic              locked;
		logic [FAIL_W-1:0] failures;
		logic [HELD_W-1:0] digits_held;
	} result_t;

	// status of the digit entry toward the lock guard
	typedef struct packed {
		logic taken;
		logic complete;
		logic user_ok;
		logic admin_ok;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/kcl_entry.sv */
`default_nettype none
module kcl_entry #(
	parameter int unsigned CODE_DIGITS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             advance,
	input  wire kcl_pkg::key_word_t               word,
	input  wire logic [kcl_pkg::CODE_W-1:0]       user_code,
	input  wire logic [kcl_pkg::CODE_W-1:0]       override_code,
	output kcl_pkg::entry_t                       entry,
	output logic [kcl_pkg::HELD_W-1:0]            digits_held
);

	localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            idx_n;
	logic [kcl_pkg::DIGIT_W-1:0] digits_q [CODE_DIGITS];
	logic [kcl_pkg::DIGIT_W-1:0] digit;
	logic                        hit;
	logic                        press;
	logic                        complete;
	logic [CODE_DIGITS-1:0]      user_eq;
	logic [CODE_DIGITS-1:0]      admin_eq;

	// lowest pressed button wins
	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int i = kcl_pkg::SCAN_BUTTONS - 1; i >= 0; i--) begin
			if (word.buttons[i]) begin
				hit   = 1'b1;
				digit = kcl_pkg::DIGIT_W'(i);
			end
		end
	end

	assign press    = (word.opcode == kcl_pkg::OP_BUTTON) && hit;
	assign complete = (idx_q == LAST_IDX);

	always_comb begin
		idx_n = idx_q;
		if (press) begin
			idx_n = complete ? '0 : idx_q + 1'b1;
		end
	end

	for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_cmp
		logic [kcl_pkg::DIGIT_W-1:0] cur;
		logic [kcl_pkg::DIGIT_W-1:0] want_user;
		logic [kcl_pkg::DIGIT_W-1:0] want_admin;

		if (g == CODE_DIGITS - 1) begin : g_new
			assign cur = digit;
		end else begin : g_old
			assign cur = digits_q[g];
		end

		// code digits past the register width compare against zero
		if (g < kcl_pkg::CODE_REG_DIGITS) begin : g_reg
			assign want_user  = user_code[g*kcl_pkg::DIGIT_W +: kcl_pkg::DIGIT_W];
			assign want_admin = override_code[g*kcl_pkg::DIGIT_W +: kcl_pkg::DIGIT_W];
		end else begin : g_zero
			assign want_user  = '0;
			assign want_admin = '0;
		end

		assign user_eq[g]  = (cur == want_user);
		assign admin_eq[g] = (cur == want_admin);
	end

	assign entry.taken    = press;
	assign entry.complete = complete;
	assign entry.user_ok  = &user_eq;
	assign entry.admin_ok = &admin_eq;
	assign digits_held    = kcl_pkg::HELD_W'(idx_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && press) begin
			digits_q[idx_q] <= digit;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/kcl_guard.sv */
`default_nettype none
module kcl_guard (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            advance,
	input  wire logic                            opcode,
	input  wire kcl_pkg::entry_t                 entry,
	input  wire logic [kcl_pkg::SECONDS_W-1:0]   lock_seconds,
	input  wire logic [kcl_pkg::FAIL_W-1:0]      warn_failures,
	input  wire logic [kcl_pkg::FAIL_W-1:0]      lock_failures,
	output kcl_pkg::event_t                      event_res,
	output logic                                 locked,
	output logic [kcl_pkg::FAIL_W-1:0]           failures
);

	logic                          lock_q;
	logic                          lock_n;
	logic [kcl_pkg::FAIL_W-1:0]    fail_q;
	logic [kcl_pkg::FAIL_W-1:0]    fail_n;
	logic [kcl_pkg::SECONDS_W-1:0] elapsed_q;
	logic [kcl_pkg::SECONDS_W-1:0] elapsed_n;
	logic [kcl_pkg::SECONDS_W-1:0] elapsed_inc;
	kcl_pkg::event_t               ev;

	assign elapsed_inc = (elapsed_q == kcl_pkg::SECONDS_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		ev        = kcl_pkg::EV_NONE;
		lock_n    = lock_q;
		fail_n    = fail_q;
		elapsed_n = elapsed_q;
		if (opcode == kcl_pkg::OP_TICK) begin
			if (lock_q) begin
				elapsed_n = elapsed_inc;
				if (elapsed_inc >= lock_seconds) begin
					lock_n    = 1'b0;
					elapsed_n = '0;
					fail_n    = '0;
					ev        = kcl_pkg::EV_EXPIRED;
				end
			end
		end else begin
			// a press after the lock time ran out unlocks first
			if (lock_q && (elapsed_q >= lock_seconds)) begin
				lock_n    = 1'b0;
				elapsed_n = '0;
				fail_n    = '0;
				ev        = kcl_pkg::EV_EXPIRED;
			end
			if (entry.taken && entry.complete) begin
				if (lock_n) begin
					if (entry.admin_ok) begin
						lock_n    = 1'b0;
						elapsed_n = '0;
						fail_n    = '0;
						ev        = kcl_pkg::EV_ADMIN;
					end else begin
						ev = kcl_pkg::EV_IGNORED;
					end
				end else if (entry.user_ok) begin
					fail_n = '0;
					ev     = kcl_pkg::EV_GRANTED;
				end else begin
					if (fail_n != kcl_pkg::FAIL_MAX) begin
						fail_n = fail_n + 1'b1;
					end
					if (fail_n == warn_failures) begin
						ev = kcl_pkg::EV_WARNING;
					end else if (fail_n >= lock_failures) begin
						lock_n    = 1'b1;
						elapsed_n = '0;
						ev        = kcl_pkg::EV_LOCKDOWN;
					end else begin
						ev = kcl_pkg::EV_DENIED;
					end
				end
			end
		end
	end

	assign event_res = ev;
	assign locked    = lock_n;
	assign failures  = fail_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q    <= 1'b0;
			fail_q    <= '0;
			elapsed_q <= '0;
		end else if (advance) begin
			lock_q    <= lock_n;
			fail_q    <= fail_n;
			elapsed_q <= elapsed_n;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/keypad_code_lock_with_lockout_top.sv */
// Channel   Signals                          Word      Direction
// input     in_valid, in_stall, in_word      key_word  into block
// output    out_valid, out_stall, out_word   result    out of block
// config    cfg_we, cfg_idx, cfg_wdata       register  into block, no read-back
//
// One word per cycle while not stalled, one result per word; each word passes
// the input register, then the result register. The lock guard and digit entry
// update between them. Reset clears the counters, the lock and the config to
// defaults; the digit store is not cleared. An output stall holds the result
// register and, with both registers full, stalls the input in the same cycle.
`default_nettype none
module keypad_code_lock_with_lockout_top #(
	parameter int unsigned CODE_DIGITS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire kcl_pkg::key_word_t                in_word,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output kcl_pkg::result_t                       out_word,
	input  wire logic                              cfg_we,
	input  wire logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [kcl_pkg::CODE_W-1:0]    user_code_q;
	logic [kcl_pkg::CODE_W-1:0]    override_code_q;
	logic [kcl_pkg::SECONDS_W-1:0] lock_seconds_q;
	logic [kcl_pkg::FAIL_W-1:0]    warn_failures_q;
	logic [kcl_pkg::FAIL_W-1:0]    lock_failures_q;

	logic               valid_s1;
	kcl_pkg::key_word_t word_s1;
	logic               valid_s2;
	kcl_pkg::result_t   res_s2;
	logic               advance;
	logic               accept;

	kcl_pkg::entry_t             entry;
	logic [kcl_pkg::HELD_W-1:0]  digits_held;
	kcl_pkg::event_t             event_res;
	logic                        locked;
	logic [kcl_pkg::FAIL_W-1:0]  failures;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign out_word  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_code_q     <= kcl_pkg::USER_CODE_RST;
			override_code_q <= kcl_pkg::OVERRIDE_CODE_RST;
			lock_seconds_q  <= kcl_pkg::LOCK_SECONDS_RST;
			warn_failures_q <= kcl_pkg::WARN_FAILURES_RST;
			lock_failures_q <= kcl_pkg::LOCK_FAILURES_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kcl_pkg::REG_USER_CODE: begin
					user_code_q <= cfg_wdata[kcl_pkg::CODE_W-1:0];
				end
				kcl_pkg::REG_OVERRIDE_CODE: begin
					override_code_q <= cfg_wdata[kcl_pkg::CODE_W-1:0];
				end
				kcl_pkg::REG_LOCK_SECONDS: begin
					lock_seconds_q <= cfg_wdata[kcl_pkg::SECONDS_W-1:0];
				end
				kcl_pkg::REG_WARN_FAILURES: begin
					warn_failures_q <= cfg_wdata[kcl_pkg::FAIL_W-1:0];
				end
				kcl_pkg::REG_LOCK_FAILURES: begin
					lock_failures_q <= cfg_wdata[kcl_pkg::FAIL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
		if (advance) begin
			res_s2.event_res   <= event_res;
			res_s2.locked      <= locked;
			res_s2.failures    <= failures;
			res_s2.digits_held <= digits_held;
		end
	end

	kcl_entry #(
		.CODE_DIGITS(CODE_DIGITS)
	) u_entry (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.word         (word_s1),
		.user_code    (user_code_q),
		.override_code(override_code_q),
		.entry        (entry),
		.digits_held  (digits_held)
	);

	kcl_guard u_guard (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.opcode       (word_s1.opcode),
		.entry        (entry),
		.lock_seconds (lock_seconds_q),
		.warn_failures(warn_failures_q),
		.lock_failures(lock_failures_q),
		.event_res    (event_res),
		.locked       (locked),
		.failures     (failures)
	);

endmodule
`default_nettype wire
